// ===== hdl/qsu_pkg.sv =====
// ----------------------------------------------------------------------------
// qsu_pkg: shared types for the quoted string unescaper
// Result record, per-byte decode bundle and error codes.
// ----------------------------------------------------------------------------
`default_nettype none

package qsu_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned ERR_W   = 3;
    localparam int unsigned DEPTH   = 4;
    localparam int unsigned PTR_W   = $clog2(DEPTH);
    localparam int unsigned CNT_W   = $clog2(DEPTH + 1);

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE      = 3'd0,
        ERR_OPEN      = 3'd1,
        ERR_CLOSE     = 3'd2,
        ERR_HEX       = 3'd3,
        ERR_TRUNCATED = 3'd4
    } t_err;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              has_byte;
        t_err              error_code;
        logic              end_of_literal;
    } t_result;

    // Results produced by one input byte: zero, one or two.
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_dec_out;

endpackage

`default_nettype wire

// ===== hdl/qsu_decode.sv =====
// ----------------------------------------------------------------------------
// qsu_decode: escape decoder
// Holds the literal's decode state and turns one byte into up to two results.
// ----------------------------------------------------------------------------
`default_nettype none

module qsu_decode (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_step,
    input  wire logic [qsu_pkg::BYTE_W-1:0]        i_byte,
    input  wire logic                              i_last,
    output qsu_pkg::t_dec_out                      o_dec
);

    typedef enum logic [2:0] {
        MODE_OPEN  = 3'd0,
        MODE_BODY  = 3'd1,
        MODE_ESC   = 3'd2,
        MODE_HEX1  = 3'd3,
        MODE_HEX2  = 3'd4,
        MODE_DRAIN = 3'd5
    } t_mode;

    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_X      = 8'h78;

    t_mode      r_mode, n_mode;
    logic       r_dquote, n_dquote;
    logic [7:0] r_hex, n_hex;

    logic [7:0] quote;
    logic       is_hex;
    logic [3:0] hex_digit;
    logic [7:0] hex_acc;

    function automatic qsu_pkg::t_result mk(input logic [7:0] b, input logic has,
                                            input qsu_pkg::t_err err, input logic fin);
        qsu_pkg::t_result r;
        r.out_byte       = b;
        r.has_byte       = has;
        r.error_code     = err;
        r.end_of_literal = fin;
        return r;
    endfunction

    always_comb begin
        quote = r_dquote ? CH_DQUOTE : CH_SQUOTE;
        is_hex    = 1'b1;
        hex_digit = 4'd0;
        if (i_byte >= 8'h30 && i_byte <= 8'h39) begin
            hex_digit = i_byte[3:0];
        end else if ((i_byte >= 8'h61 && i_byte <= 8'h66) ||
                     (i_byte >= 8'h41 && i_byte <= 8'h46)) begin
            hex_digit = i_byte[3:0] + 4'd9;
        end else begin
            is_hex = 1'b0;
        end
        hex_acc = {r_hex[3:0], hex_digit};
    end

    always_comb begin
        n_mode   = r_mode;
        n_dquote = r_dquote;
        n_hex    = r_hex;
        o_dec.count = 2'd0;
        o_dec.res0  = mk(8'h00, 1'b0, qsu_pkg::ERR_NONE, 1'b0);
        o_dec.res1  = mk(8'h00, 1'b0, qsu_pkg::ERR_NONE, 1'b0);
        unique case (r_mode)
            MODE_OPEN: begin
                if (i_byte != CH_DQUOTE && i_byte != CH_SQUOTE) begin
                    o_dec.count = 2'd1;
                    o_dec.res0  = mk(8'h00, 1'b0, qsu_pkg::ERR_OPEN, i_last);
                    n_mode      = i_last ? MODE_OPEN : MODE_DRAIN;
                end else if (i_last) begin
                    o_dec.count = 2'd1;
                    o_dec.res0  = mk(8'h00, 1'b0, qsu_pkg::ERR_CLOSE, 1'b1);
                end else begin
                    n_dquote = (i_byte == CH_DQUOTE);
                    n_mode   = MODE_BODY;
                end
            end
            MODE_BODY: begin
                if (i_last) begin
                    o_dec.count = 2'd1;
                    o_dec.res0  = mk(8'h00, 1'b0,
                                     (i_byte == quote) ? qsu_pkg::ERR_NONE
                                                       : qsu_pkg::ERR_CLOSE, 1'b1);
                    n_mode      = MODE_OPEN;
                end else if (i_byte == CH_BSLASH) begin
                    n_mode = MODE_ESC;
                end else begin
                    o_dec.count = 2'd1;
                    o_dec.res0  = mk(i_byte, 1'b1, qsu_pkg::ERR_NONE, 1'b0);
                end
            end
            MODE_ESC: begin
                if (i_last) begin
                    o_dec.count = 2'd1;
                    o_dec.res0  = mk(8'h00, 1'b0, qsu_pkg::ERR_TRUNCATED, 1'b1);
                    n_mode      = MODE_OPEN;
                end else begin
                    n_mode      = MODE_BODY;
                    o_dec.count = 2'd1;
                    unique case (i_byte)
                        8'h61:     o_dec.res0 = mk(8'h07, 1'b1, qsu_pkg::ERR_NONE, 1'b0);
                        8'h62:     o_dec.res0 = mk(8'h08, 1'b1, qsu_pkg::ERR_NONE, 1'b0);
                        8'h74:     o_dec.res0 = mk(8'h09, 1'b1, qsu_pkg::ERR_NONE, 1'b0);
                        8'h6E:     o_dec.res0 = mk(8'h0A, 1'b1, qsu_pkg::ERR_NONE, 1'b0);
                        8'h76:     o_dec.res0 = mk(8'h0B, 1'b1, qsu_pkg::ERR_NONE, 1'b0);
                        8'h66:     o_dec.res0 = mk(8'h0C, 1'b1, qsu_pkg::ERR_NONE, 1'b0);
                        8'h72:     o_dec.res0 = mk(8'h0D, 1'b1, qsu_pkg::ERR_NONE, 1'b0);
                        CH_BSLASH: o_dec.res0 = mk(CH_BSLASH, 1'b1, qsu_pkg::ERR_NONE, 1'b0);
                        CH_X: begin
                            o_dec.count = 2'd0;
                            n_hex       = 8'h00;
                            n_mode      = MODE_HEX1;
                        end
                        default: begin
                            // unknown escape: keep the backslash, then the byte
                            o_dec.count = 2'd2;
                            o_dec.res0  = mk(CH_BSLASH, 1'b1, qsu_pkg::ERR_NONE, 1'b0);
                            o_dec.res1  = mk(i_byte, 1'b1, qsu_pkg::ERR_NONE, 1'b0);
                        end
                    endcase
                end
            end
            MODE_HEX1, MODE_HEX2: begin
                if (i_last) begin
                    o_dec.count = 2'd1;
                    o_dec.res0  = mk(8'h00, 1'b0, qsu_pkg::ERR_TRUNCATED, 1'b1);
                    n_mode      = MODE_OPEN;
                end else if (!is_hex) begin
                    o_dec.count = 2'd1;
                    o_dec.res0  = mk(8'h00, 1'b0, qsu_pkg::ERR_HEX, 1'b0);
                    n_mode      = MODE_DRAIN;
                end else begin
                    n_hex = hex_acc;
                    if (r_mode == MODE_HEX1) begin
                        n_mode = MODE_HEX2;
                    end else begin
                        o_dec.count = 2'd1;
                        o_dec.res0  = mk(hex_acc, 1'b1, qsu_pkg::ERR_NONE, 1'b0);
                        n_mode      = MODE_BODY;
                    end
                end
            end
            default: begin
                // drop bytes until the literal ends
                if (i_last) begin
                    o_dec.count = 2'd1;
                    o_dec.res0  = mk(8'h00, 1'b0, qsu_pkg::ERR_NONE, 1'b1);
                    n_mode      = MODE_OPEN;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_OPEN;
            r_dquote <= 1'b0;
            r_hex    <= 8'h00;
        end else if (i_step) begin
            r_mode   <= n_mode;
            r_dquote <= n_dquote;
            r_hex    <= n_hex;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/qsu_out_fifo.sv =====
// ----------------------------------------------------------------------------
// qsu_out_fifo: result queue
// Takes up to two results per cycle, hands out one per request.
// ----------------------------------------------------------------------------
`default_nettype none

module qsu_out_fifo (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  qsu_pkg::t_dec_out         i_dec,
    output logic                      o_room,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output qsu_pkg::t_result          o_res
);

    qsu_pkg::t_result                 r_mem [qsu_pkg::DEPTH];
    logic [qsu_pkg::PTR_W-1:0]        r_wr_ptr, n_wr_ptr;
    logic [qsu_pkg::PTR_W-1:0]        r_rd_ptr, n_rd_ptr;
    logic [qsu_pkg::CNT_W-1:0]        r_count, n_count;
    logic [1:0]                       push_n;
    logic                             pop;

    assign o_room  = (r_count <= qsu_pkg::CNT_W'(qsu_pkg::DEPTH - 2));
    assign o_valid = (r_count != '0);
    assign o_res   = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_ready;
    assign push_n  = i_push ? i_dec.count : 2'd0;

    always_comb begin
        n_wr_ptr = r_wr_ptr + qsu_pkg::PTR_W'(push_n);
        n_rd_ptr = r_rd_ptr + qsu_pkg::PTR_W'(pop);
        n_count  = r_count + qsu_pkg::CNT_W'(push_n) - qsu_pkg::CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_mem[r_wr_ptr] <= i_dec.res0;
        end
        if (push_n == 2'd2) begin
            r_mem[r_wr_ptr + qsu_pkg::PTR_W'(1)] <= i_dec.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/quoted_string_unescaper_unit.sv =====
// ----------------------------------------------------------------------------
// quoted_string_unescaper_unit: quoted literal escape decoder
// Input register, escape decoder and a four-entry result queue.
// ----------------------------------------------------------------------------
// Feed the literal one byte per request, opening quote first, closing quote
// with tlast. The unit accepts one byte per cycle while the result queue
// has room; a byte is held in the input register, then its results go
// into the result queue that feeds the output port. Each byte yields zero,
// one or two results, and the output port hands out one result per cycle
// while tready is high, so an unknown escape (backslash plus copied byte)
// yields two results; input stalls only when the four-entry result queue
// cannot take two more results. Errors: 1 bad opening quote, 2 closing mismatch,
// 3 bad hex digit, 4 escape cut short; after error 1 or 3 bytes are dropped until tlast.
`default_nettype none

module quoted_string_unescaper_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] in_byte
    input  wire logic        i_s_tlast,   // in_last
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata,   // [7:0] out_byte, [10:8] error_code, rest 0
    output logic             o_m_tuser,   // has_byte
    output logic             o_m_tlast    // end_of_literal
);

    logic                          r_in_valid;
    logic [qsu_pkg::BYTE_W-1:0]    r_in_byte;
    logic                          r_in_last;
    logic                          room;
    logic                          step;
    qsu_pkg::t_dec_out             dec;
    qsu_pkg::t_result              res;

    assign step       = r_in_valid && room;
    assign o_s_tready = !r_in_valid || room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    qsu_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_dec   (dec)
    );

    qsu_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (step),
        .i_dec   (dec),
        .o_room  (room),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (res)
    );

    assign o_m_tdata = {5'd0, res.error_code, res.out_byte};
    assign o_m_tuser = res.has_byte;
    assign o_m_tlast = res.end_of_literal;

endmodule

`default_nettype wire
